// ===== sv/ps2kb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ps2kb_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int OPQ_DEPTH       = 2;

    localparam logic [7:0] LED_CMD       = 8'hED;
    localparam logic [7:0] ACK_BYTE      = 8'hFA;
    localparam logic [7:0] RESEND_BYTE   = 8'hFE;
    localparam logic [7:0] TABLE_SIZE    = 8'h54;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_NUM        = 8'h45;
    localparam logic [7:0] SC_SCROLL     = 8'h46;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_CTRL       = 8'h1D;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
    localparam logic [7:0] SC_BKSP       = 8'h0E;
    localparam logic [7:0] SC_ENTER      = 8'h1C;

    localparam logic [7:0] ASCII_BS      = 8'h08;
    localparam logic [7:0] ASCII_LF      = 8'h0A;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE    = 8'h20;

    localparam logic [2:0] LED_CAPS      = 3'b100;
    localparam logic [2:0] LED_NUM       = 3'b010;
    localparam logic [2:0] LED_SCROLL    = 3'b001;

    localparam logic REQ_KEY    = 1'b0;
    localparam logic REQ_START  = 1'b1;
    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_TX    = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] scancode;
    } req_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_value;
        logic       ctrl_held;
        logic       last;
    } res_t;

    // classified transaction handed from front to back
    typedef struct packed {
        logic       has_char;
        logic [7:0] char_val;
        logic       ctrl;
        logic       push_led;
        logic [2:0] led_val;
        logic       is_ack;
        logic       is_resend;
    } op_t;

    function automatic logic [7:0] plain_char(input logic [6:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                7'h02: c = 8'h31;  7'h03: c = 8'h32;  7'h04: c = 8'h33;  7'h05: c = 8'h34;
                7'h06: c = 8'h35;  7'h07: c = 8'h36;  7'h08: c = 8'h37;  7'h09: c = 8'h38;
                7'h0A: c = 8'h39;  7'h0B: c = 8'h30;  7'h0C: c = 8'h2D;  7'h0D: c = 8'h3D;
                7'h10: c = 8'h51;  7'h11: c = 8'h57;  7'h12: c = 8'h45;  7'h13: c = 8'h52;
                7'h14: c = 8'h54;  7'h15: c = 8'h59;  7'h16: c = 8'h55;  7'h17: c = 8'h49;
                7'h18: c = 8'h4F;  7'h19: c = 8'h50;  7'h1A: c = 8'h5B;  7'h1B: c = 8'h5D;
                7'h1E: c = 8'h41;  7'h1F: c = 8'h53;
                7'h20: c = 8'h44;  7'h21: c = 8'h46;  7'h22: c = 8'h47;  7'h23: c = 8'h48;
                7'h24: c = 8'h4A;  7'h25: c = 8'h4B;  7'h26: c = 8'h4C;  7'h27: c = 8'h3B;
                7'h28: c = 8'h27;  7'h29: c = 8'h60;  7'h2B: c = 8'h5C;  7'h2C: c = 8'h5A;
                7'h2D: c = 8'h58;  7'h2E: c = 8'h43;  7'h2F: c = 8'h56;
                7'h30: c = 8'h42;  7'h31: c = 8'h4E;  7'h32: c = 8'h4D;  7'h33: c = 8'h2C;
                7'h34: c = 8'h2E;  7'h35: c = 8'h2F;  7'h37: c = 8'h2A;  7'h39: c = 8'h20;
                7'h47: c = 8'h37;  7'h48: c = 8'h38;  7'h49: c = 8'h39;  7'h4A: c = 8'h2D;
                7'h4B: c = 8'h34;  7'h4C: c = 8'h35;  7'h4D: c = 8'h36;  7'h4E: c = 8'h2B;
                7'h4F: c = 8'h31;  7'h50: c = 8'h32;  7'h51: c = 8'h33;  7'h52: c = 8'h30;
                7'h53: c = 8'h2E;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] shift_char(input logic [6:0] idx);
        logic [7:0] c;
        begin
            unique case (idx)
                7'h02: c = 8'h21;  7'h03: c = 8'h40;  7'h04: c = 8'h23;  7'h05: c = 8'h24;
                7'h06: c = 8'h25;  7'h07: c = 8'h5E;  7'h08: c = 8'h26;  7'h09: c = 8'h2A;
                7'h0A: c = 8'h28;  7'h0B: c = 8'h29;  7'h0C: c = 8'h5F;  7'h0D: c = 8'h2B;
                7'h1A: c = 8'h7B;  7'h1B: c = 8'h7D;  7'h27: c = 8'h3A;  7'h28: c = 8'h22;
                7'h29: c = 8'h7E;  7'h2B: c = 8'h7C;  7'h33: c = 8'h3C;  7'h34: c = 8'h3E;
                7'h35: c = 8'h3F;
                default: c = plain_char(idx);
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/scancode_to_ascii_with_led_cmd.sv =====
// Set-1 keyboard byte decoder with keyboard LED command queue.
// Input channel s_*: one transaction per received keyboard byte (req_type 0)
// or per start request (req_type 1, loads the LEDs from cfg_wr_data's
// register and queues the LED command).
// Output channel m_*: characters for the host (out_kind 0) and bytes to send
// to the keyboard (out_kind 1); last marks the final result of an input.
// cfg_wr_en/cfg_wr_data write init_leds_reg directly, no wait.
// The first result of an accepted input passes through the op queue and
// then the result register before it is presented on m_*.
// Throughput: one input per cycle while m_ready is high and it yields at
// most one result; an input with two results holds off the next until the
// two-entry result buffer drains, as the back end refills it only then.
// Reset clears modifiers, LEDs, the command queue and the ack wait.
// If m_ready stays low the result buffer holds, the two-entry op queue
// fills and then s_ready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module scancode_to_ascii_with_led_cmd #(
    parameter int QUEUE_DEPTH = ps2kb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [2:0]      cfg_wr_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ps2kb_pkg::req_t s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ps2kb_pkg::res_t      m_data
);
    logic           fr_valid, fr_ready;
    ps2kb_pkg::op_t fr_data;
    logic           bk_valid, bk_ready;
    ps2kb_pkg::op_t bk_data;

    ps2kb_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .op_valid    (fr_valid),
        .op_ready    (fr_ready),
        .op_data     (fr_data)
    );

    ps2kb_fifo #(
        .WIDTH ($bits(ps2kb_pkg::op_t)),
        .DEPTH (ps2kb_pkg::OPQ_DEPTH)
    ) u_opq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    ps2kb_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (bk_valid),
        .op_ready (bk_ready),
        .op_data  (bk_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire

// ===== sv/ps2kb_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ps2kb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/ps2kb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ps2kb_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [2:0]        cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ps2kb_pkg::req_t   s_data,
    output logic                   op_valid,
    input  wire logic              op_ready,
    output ps2kb_pkg::op_t         op_data
);
    logic [2:0] init_leds_reg;
    logic [1:0] shift_reg, shift_next;
    logic       ctrl_reg, ctrl_next;
    logic [2:0] lock_reg, lock_next;
    logic [7:0] code;
    logic [7:0] ch;
    logic       accept;

    assign code     = s_data.scancode;
    assign op_valid = s_valid;
    assign s_ready  = op_ready;
    assign accept   = s_valid && op_ready;

    always_comb begin
        ch         = 8'h00;
        op_data    = '0;
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        lock_next  = lock_reg;
        if (s_data.req_type == ps2kb_pkg::REQ_START) begin
            lock_next        = init_leds_reg;
            op_data.push_led = 1'b1;
            op_data.led_val  = init_leds_reg;
        end else begin
            if (code < ps2kb_pkg::TABLE_SIZE) begin
                ch = (shift_reg == 2'b00) ? ps2kb_pkg::plain_char(code[6:0])
                                          : ps2kb_pkg::shift_char(code[6:0]);
            end
            if (ch >= ps2kb_pkg::ASCII_UPPER_A && ch <= ps2kb_pkg::ASCII_UPPER_Z &&
                (lock_reg[2] == (shift_reg != 2'b00))) begin
                ch = ch + ps2kb_pkg::ASCII_CASE;
            end
            if (code == ps2kb_pkg::SC_BKSP) begin
                ch = ps2kb_pkg::ASCII_BS;
            end
            if (code == ps2kb_pkg::SC_ENTER) begin
                ch = ps2kb_pkg::ASCII_LF;
            end
            op_data.has_char = (ch != 8'h00);
            op_data.char_val = ch;
            op_data.ctrl     = ctrl_reg;

            unique case (code)
                ps2kb_pkg::SC_CTRL:       ctrl_next = 1'b1;
                ps2kb_pkg::SC_CTRL_BRK:   ctrl_next = 1'b0;
                ps2kb_pkg::SC_LSHIFT:     shift_next = shift_reg | 2'b01;
                ps2kb_pkg::SC_RSHIFT:     shift_next = shift_reg | 2'b10;
                ps2kb_pkg::SC_LSHIFT_BRK: shift_next = shift_reg & 2'b10;
                ps2kb_pkg::SC_RSHIFT_BRK: shift_next = shift_reg & 2'b01;
                ps2kb_pkg::SC_CAPS: begin
                    lock_next        = lock_reg ^ ps2kb_pkg::LED_CAPS;
                    op_data.push_led = 1'b1;
                    op_data.led_val  = lock_next;
                end
                ps2kb_pkg::SC_NUM: begin
                    lock_next        = lock_reg ^ ps2kb_pkg::LED_NUM;
                    op_data.push_led = 1'b1;
                    op_data.led_val  = lock_next;
                end
                ps2kb_pkg::SC_SCROLL: begin
                    lock_next        = lock_reg ^ ps2kb_pkg::LED_SCROLL;
                    op_data.push_led = 1'b1;
                    op_data.led_val  = lock_next;
                end
                ps2kb_pkg::ACK_BYTE:      op_data.is_ack = 1'b1;
                ps2kb_pkg::RESEND_BYTE:   op_data.is_resend = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_leds_reg <= '0;
            shift_reg     <= '0;
            ctrl_reg      <= 1'b0;
            lock_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                init_leds_reg <= cfg_wr_data;
            end
            if (accept) begin
                shift_reg <= shift_next;
                ctrl_reg  <= ctrl_next;
                lock_reg  <= lock_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/ps2kb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ps2kb_back #(
    parameter int QUEUE_DEPTH = ps2kb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             op_valid,
    output logic                  op_ready,
    input  wire ps2kb_pkg::op_t   op_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output ps2kb_pkg::res_t       m_data
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]    q_mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next, tail_inc;
    logic [CW-1:0] count_reg, count_next, c1, c2;
    logic          awaiting_reg, awaiting_next;
    logic [7:0]    pending_reg, pending_next;

    logic [1:0]      buf_cnt_reg, buf_cnt_next;
    ps2kb_pkg::res_t res0_reg, res0_next;
    ps2kb_pkg::res_t res1_reg, res1_next;

    logic            pop, take;
    logic            push0, push1, wait_now, has_first, deq;
    logic [7:0]      deq_byte;
    ps2kb_pkg::res_t first_res, deq_res;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign m_valid  = (buf_cnt_reg != 2'd0);
    assign m_data   = res0_reg;
    assign pop      = m_valid && m_ready;
    assign op_ready = (buf_cnt_reg == 2'd0) || (buf_cnt_reg == 2'd1 && pop);
    assign take     = op_valid && op_ready;
    assign tail_inc = wrap_inc(tail_reg);

    always_comb begin
        push0     = op_data.push_led && (count_reg < CW'(QUEUE_DEPTH));
        c1        = count_reg + CW'(push0);
        push1     = op_data.push_led && (c1 < CW'(QUEUE_DEPTH));
        c2        = c1 + CW'(push1);
        wait_now  = awaiting_reg && !op_data.is_ack;
        has_first = op_data.has_char || (op_data.is_resend && awaiting_reg);
        deq       = !wait_now && (c2 != '0);
        // empty queue: the byte leaving is the command just pushed
        deq_byte  = (count_reg == '0) ? ps2kb_pkg::LED_CMD : q_mem_reg[head_reg];

        if (op_data.has_char) begin
            first_res.out_kind  = ps2kb_pkg::KIND_CHAR;
            first_res.out_value = op_data.char_val;
            first_res.ctrl_held = op_data.ctrl;
        end else begin
            first_res.out_kind  = ps2kb_pkg::KIND_TX;
            first_res.out_value = pending_reg;
            first_res.ctrl_held = 1'b0;
        end
        first_res.last = !deq;

        deq_res.out_kind  = ps2kb_pkg::KIND_TX;
        deq_res.out_value = deq_byte;
        deq_res.ctrl_held = 1'b0;
        deq_res.last      = 1'b1;

        head_next     = deq ? wrap_inc(head_reg) : head_reg;
        tail_next     = push1 ? wrap_inc(tail_inc) : (push0 ? tail_inc : tail_reg);
        count_next    = c2 - CW'(deq);
        awaiting_next = deq ? 1'b1 : wait_now;
        pending_next  = deq ? deq_byte : pending_reg;

        buf_cnt_next = buf_cnt_reg;
        res0_next    = res0_reg;
        res1_next    = res1_reg;
        if (take) begin
            buf_cnt_next = {1'b0, has_first} + {1'b0, deq};
            res0_next    = has_first ? first_res : deq_res;
            res1_next    = deq_res;
        end else if (pop) begin
            buf_cnt_next = buf_cnt_reg - 2'd1;
            res0_next    = res1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            awaiting_reg <= 1'b0;
            pending_reg  <= '0;
            buf_cnt_reg  <= '0;
        end else begin
            if (take) begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                count_reg    <= count_next;
                awaiting_reg <= awaiting_next;
                pending_reg  <= pending_next;
            end
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
        if (take && push0) begin
            q_mem_reg[tail_reg] <= ps2kb_pkg::LED_CMD;
        end
        if (take && push1) begin
            q_mem_reg[tail_inc] <= {5'b00000, op_data.led_val};
        end
    end

endmodule
`default_nettype wire

// ===== sv/ps2kb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ps2kb_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            cfg_wr_en,
    input wire logic [2:0]      cfg_wr_data,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire ps2kb_pkg::req_t s_data,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire ps2kb_pkg::res_t m_data
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_tx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == ps2kb_pkg::KIND_TX |->
            m_data.last && !m_data.ctrl_held)
        else $error("keyboard byte not last or carries ctrl");

    a_char_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_kind == ps2kb_pkg::KIND_CHAR |-> m_data.out_value != 8'h00)
        else $error("null character delivered");

    a_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_valid)
        else $error("second result of a transaction missing");

endmodule

bind scancode_to_ascii_with_led_cmd ps2kb_checker u_ps2kb_checker (.*);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int          CMDQ_DEPTH    = ps2kb_pkg::QUEUE_DEPTH_DEF;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PARK_CYCLES   = 400;
    localparam int unsigned RUN_LIMIT     = 800000;
    localparam logic [7:0]  SC_ALT        = 8'h38;
    localparam logic [7:0]  SC_ALT_BRK    = 8'hB8;
    localparam logic [7:0]  NO_KEY        = "#";

    typedef struct packed {
        logic            typed;
        logic [1:0]      cnt;
        ps2kb_pkg::res_t r0;
        ps2kb_pkg::res_t r1;
    } exp_note_t;

    typedef struct packed {
        ps2kb_pkg::req_t rq;
        exp_note_t       nt;
    } dir_row_t;

    logic            aclk        = 1'b0;
    logic            aresetn     = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [2:0]      cfg_wr_data = 3'b000;
    logic            s_valid     = 1'b0;
    logic            s_ready;
    ps2kb_pkg::req_t s_data      = '0;
    exp_note_t       s_note      = '0;
    logic            m_valid;
    logic            m_ready     = 1'b0;
    ps2kb_pkg::res_t m_data;

    // decoder state as seen from outside
    logic [1:0] shift_down   = 2'b00;
    logic       ctrl_down    = 1'b0;
    logic [2:0] led_state    = 3'b000;
    logic [2:0] led_preset   = 3'b000;
    logic [7:0] kbd_cmds [CMDQ_DEPTH];
    int         kbd_cmd_cnt  = 0;
    int         kbd_cmd_head = 0;
    logic       ack_wait     = 1'b0;
    logic [7:0] sent_byte    = 8'h00;

    ps2kb_pkg::res_t due_results [$];
    int              mismatches  = 0;
    int unsigned     cycle_count = 0;
    logic            calm        = 1'b0;
    logic            storm       = 1'b0;
    logic            park_req    = 1'b0;
    logic            park_done   = 1'b0;

    // unshifted key map, '#' marks codes with no character
    string plain_rows = {"##1234567890-=##", "QWERTYUIOP[]##AS", "DFGHJKL;'\140#\\ZXCV",
                         "BNM,./#*# ######", "#######789-456+1", "230."};

    scancode_to_ascii_with_led_cmd DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("scancode_to_ascii_with_led_cmd verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] plain_key(input logic [7:0] sc);
        logic [7:0] c;
        c = plain_rows[sc];
        return (c == NO_KEY) ? 8'h00 : c;
    endfunction

    function automatic logic [7:0] shifted_key(input logic [7:0] sc);
        logic [7:0] c;
        case (sc)
            8'h02: c = "!";
            8'h03: c = "@";
            8'h04: c = "#";
            8'h05: c = "$";
            8'h06: c = "%";
            8'h07: c = "^";
            8'h08: c = "&";
            8'h09: c = "*";
            8'h0A: c = "(";
            8'h0B: c = ")";
            8'h0C: c = "_";
            8'h0D: c = "+";
            8'h1A: c = "{";
            8'h1B: c = "}";
            8'h27: c = ":";
            8'h28: c = "\"";
            8'h29: c = "~";
            8'h2B: c = "|";
            8'h33: c = "<";
            8'h34: c = ">";
            8'h35: c = "?";
            default: c = plain_key(sc);
        endcase
        return c;
    endfunction

    // LED command and LED byte, each dropped on its own when the queue is full
    function automatic void queue_led_cmd();
        logic [7:0] b [2];
        b[0] = ps2kb_pkg::LED_CMD;
        b[1] = {5'b00000, led_state};
        foreach (b[i]) begin
            if (kbd_cmd_cnt < CMDQ_DEPTH) begin
                kbd_cmds[(kbd_cmd_head + kbd_cmd_cnt) % CMDQ_DEPTH] = b[i];
                kbd_cmd_cnt++;
            end
        end
    endfunction

    function automatic int decode_byte(input ps2kb_pkg::req_t rq,
                                       output ps2kb_pkg::res_t r0,
                                       output ps2kb_pkg::res_t r1);
        ps2kb_pkg::res_t rs [2];
        int              n;
        logic [7:0]      ch;
        logic [7:0]      sc;
        n = 0;
        rs[0] = '0;
        rs[1] = '0;
        ch = 8'h00;
        sc = rq.scancode;
        if (rq.req_type == ps2kb_pkg::REQ_START) begin
            led_state = led_preset;
            queue_led_cmd();
        end else begin
            if (sc < ps2kb_pkg::TABLE_SIZE)
                ch = (shift_down == 2'b00) ? plain_key(sc) : shifted_key(sc);
            if (ch >= ps2kb_pkg::ASCII_UPPER_A && ch <= ps2kb_pkg::ASCII_UPPER_Z
                    && ((led_state & ps2kb_pkg::LED_CAPS) != 3'b000) == (shift_down != 2'b00))
                ch = ch + ps2kb_pkg::ASCII_CASE;
            if (sc == ps2kb_pkg::SC_BKSP)
                ch = ps2kb_pkg::ASCII_BS;
            if (sc == ps2kb_pkg::SC_ENTER)
                ch = ps2kb_pkg::ASCII_LF;
            if (ch != 8'h00) begin
                rs[n] = '{ps2kb_pkg::KIND_CHAR, ch, ctrl_down, 1'b0};
                n++;
            end
            case (sc)
                ps2kb_pkg::SC_CTRL:       ctrl_down = 1'b1;
                ps2kb_pkg::SC_CTRL_BRK:   ctrl_down = 1'b0;
                ps2kb_pkg::SC_LSHIFT:     shift_down[0] = 1'b1;
                ps2kb_pkg::SC_RSHIFT:     shift_down[1] = 1'b1;
                ps2kb_pkg::SC_LSHIFT_BRK: shift_down[0] = 1'b0;
                ps2kb_pkg::SC_RSHIFT_BRK: shift_down[1] = 1'b0;
                ps2kb_pkg::SC_CAPS: begin
                    led_state ^= ps2kb_pkg::LED_CAPS;
                    queue_led_cmd();
                end
                ps2kb_pkg::SC_NUM: begin
                    led_state ^= ps2kb_pkg::LED_NUM;
                    queue_led_cmd();
                end
                ps2kb_pkg::SC_SCROLL: begin
                    led_state ^= ps2kb_pkg::LED_SCROLL;
                    queue_led_cmd();
                end
                ps2kb_pkg::ACK_BYTE:      ack_wait = 1'b0;
                ps2kb_pkg::RESEND_BYTE: begin
                    if (ack_wait) begin
                        rs[n] = '{ps2kb_pkg::KIND_TX, sent_byte, 1'b0, 1'b0};
                        n++;
                    end
                end
                default: ;
            endcase
        end
        if (!ack_wait && kbd_cmd_cnt > 0 && n < 2) begin
            sent_byte = kbd_cmds[kbd_cmd_head];
            kbd_cmd_head = (kbd_cmd_head + 1) % CMDQ_DEPTH;
            kbd_cmd_cnt--;
            ack_wait = 1'b1;
            rs[n] = '{ps2kb_pkg::KIND_TX, sent_byte, 1'b0, 1'b0};
            n++;
        end
        if (n > 0)
            rs[n - 1].last = 1'b1;
        r0 = rs[0];
        r1 = rs[1];
        return n;
    endfunction

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (mismatches < 40)
            $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        ps2kb_pkg::res_t want;
        ps2kb_pkg::res_t p0;
        ps2kb_pkg::res_t p1;
        int              n;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result with nothing due", m_data.out_value, 8'h00);
                end else begin
                    want = due_results.pop_front();
                    if (m_data.out_kind !== want.out_kind)
                        flag_mismatch("out_kind", m_data.out_kind, want.out_kind);
                    if (m_data.out_value !== want.out_value)
                        flag_mismatch("out_value", m_data.out_value, want.out_value);
                    if (m_data.ctrl_held !== want.ctrl_held)
                        flag_mismatch("ctrl_held", m_data.ctrl_held, want.ctrl_held);
                    if (m_data.last !== want.last)
                        flag_mismatch("last", m_data.last, want.last);
                end
            end
            if (s_valid && s_ready) begin
                n = decode_byte(s_data, p0, p1);
                if (s_note.typed) begin
                    n = s_note.cnt;
                    p0 = s_note.r0;
                    p1 = s_note.r1;
                end
                if (n > 0)
                    due_results.push_back(p0);
                if (n > 1)
                    due_results.push_back(p1);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin : sink
        int hold;
        forever begin
            @(posedge aclk);
            if (park_req && !park_done) begin
                m_ready <= 1'b0;
                repeat (PARK_CYCLES) @(posedge aclk);
                park_done = 1'b1;
                m_ready <= 1'b1;
            end else begin
                hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (hold > 0) begin
                    m_ready <= 1'b0;
                    repeat (hold) @(posedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    function automatic ps2kb_pkg::req_t pick_item();
        ps2kb_pkg::req_t rq;
        int              r;
        int              t_lock;
        int              t_ack;
        int              t_resend;
        int              t_mod;
        int              t_noise;
        int              t_break;
        t_lock   = 3 + (storm ? 40 : 8);
        t_ack    = t_lock + (storm ? 4 : 12);
        t_resend = t_ack + 5;
        t_mod    = t_resend + 10;
        t_noise  = t_mod + 10;
        t_break  = t_noise + 8;
        r = $urandom_range(0, 99);
        rq.req_type = ps2kb_pkg::REQ_KEY;
        rq.scancode = 8'($urandom_range(0, 255));
        if (r < 3) begin
            rq.req_type = ps2kb_pkg::REQ_START;
        end else if (r < t_lock) begin
            case ($urandom_range(0, 2))
                0:       rq.scancode = ps2kb_pkg::SC_CAPS;
                1:       rq.scancode = ps2kb_pkg::SC_NUM;
                default: rq.scancode = ps2kb_pkg::SC_SCROLL;
            endcase
        end else if (r < t_ack) begin
            rq.scancode = ps2kb_pkg::ACK_BYTE;
        end else if (r < t_resend) begin
            rq.scancode = ps2kb_pkg::RESEND_BYTE;
        end else if (r < t_mod) begin
            case ($urandom_range(0, 7))
                0:       rq.scancode = ps2kb_pkg::SC_CTRL;
                1:       rq.scancode = ps2kb_pkg::SC_LSHIFT;
                2:       rq.scancode = ps2kb_pkg::SC_RSHIFT;
                3:       rq.scancode = SC_ALT;
                4:       rq.scancode = ps2kb_pkg::SC_CTRL_BRK;
                5:       rq.scancode = ps2kb_pkg::SC_LSHIFT_BRK;
                6:       rq.scancode = ps2kb_pkg::SC_RSHIFT_BRK;
                default: rq.scancode = SC_ALT_BRK;
            endcase
        end else if (r < t_noise) begin
            rq.scancode = rq.scancode;
        end else if (r < t_break) begin
            rq.scancode = 8'($urandom_range(0, 8'h53)) | 8'h80;
        end else begin
            rq.scancode = 8'($urandom_range(0, 8'h53));
        end
        return rq;
    endfunction

    task automatic send_req(input ps2kb_pkg::req_t rq, input exp_note_t nt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        s_note  <= nt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_leds(input logic [2:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        led_preset = v;
    endtask

    function automatic dir_row_t row_key(input logic [7:0] sc);
        dir_row_t row;
        row = '0;
        row.rq = '{ps2kb_pkg::REQ_KEY, sc};
        return row;
    endfunction

    function automatic dir_row_t row_none(input logic [7:0] sc);
        dir_row_t row;
        row = row_key(sc);
        row.nt.typed = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t row_one(input logic [7:0] sc, input logic kind,
                                         input logic [7:0] value, input logic ctl);
        dir_row_t row;
        row = row_none(sc);
        row.nt.cnt = 2'd1;
        row.nt.r0 = '{kind, value, ctl, 1'b1};
        return row;
    endfunction

    initial begin : stimulus
        dir_row_t        script [27];
        ps2kb_pkg::req_t rq;
        script = '{
            row_none(8'h00),
            row_none(8'hFF),
            row_one(8'h1E, ps2kb_pkg::KIND_CHAR, 8'h61, 1'b0),
            row_one(ps2kb_pkg::SC_BKSP, ps2kb_pkg::KIND_CHAR, ps2kb_pkg::ASCII_BS, 1'b0),
            row_one(ps2kb_pkg::SC_ENTER, ps2kb_pkg::KIND_CHAR, ps2kb_pkg::ASCII_LF, 1'b0),
            row_one(8'h53, ps2kb_pkg::KIND_CHAR, 8'h2E, 1'b0),
            row_none(ps2kb_pkg::TABLE_SIZE),
            row_none(ps2kb_pkg::SC_LSHIFT),
            row_one(8'h02, ps2kb_pkg::KIND_CHAR, 8'h21, 1'b0),
            row_one(8'h1E, ps2kb_pkg::KIND_CHAR, 8'h41, 1'b0),
            row_none(ps2kb_pkg::SC_RSHIFT),
            row_none(ps2kb_pkg::SC_LSHIFT_BRK),
            row_one(8'h35, ps2kb_pkg::KIND_CHAR, 8'h3F, 1'b0),
            row_none(ps2kb_pkg::SC_RSHIFT_BRK),
            row_none(ps2kb_pkg::SC_CTRL),
            row_one(8'h2E, ps2kb_pkg::KIND_CHAR, 8'h63, 1'b1),
            row_none(ps2kb_pkg::SC_CTRL_BRK),
            row_key(SC_ALT),
            row_one(ps2kb_pkg::SC_CAPS, ps2kb_pkg::KIND_TX, ps2kb_pkg::LED_CMD, 1'b0),
            row_one(ps2kb_pkg::RESEND_BYTE, ps2kb_pkg::KIND_TX, ps2kb_pkg::LED_CMD, 1'b0),
            row_one(ps2kb_pkg::ACK_BYTE, ps2kb_pkg::KIND_TX,
                    {5'b00000, ps2kb_pkg::LED_CAPS}, 1'b0),
            row_one(8'h1E, ps2kb_pkg::KIND_CHAR, 8'h41, 1'b0),
            row_key(ps2kb_pkg::SC_NUM),
            row_key(ps2kb_pkg::SC_SCROLL),
            row_key(ps2kb_pkg::ACK_BYTE),
            '{rq: '{ps2kb_pkg::REQ_START, 8'hFF}, nt: '0},
            row_key(SC_ALT_BRK)
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (script[i])
            send_req(script[i].rq, script[i].nt);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0:       write_leds(3'b111);
                1:       write_leds(3'b000);
                default: write_leds(3'($urandom_range(0, 7)));
            endcase
            calm  = (ph == 3);
            storm = (ph == 5 || ph == 6);
            if (ph == 4)
                park_req = 1'b1;
            rq.req_type = ps2kb_pkg::REQ_START;
            rq.scancode = 8'($urandom_range(0, 255));
            send_req(rq, '0);
            repeat (96) send_req(pick_item(), '0);
        end

        settle();
        if (mismatches == 0) begin
            $display("scancode_to_ascii_with_led_cmd verification clean");
        end else begin
            $display("scancode_to_ascii_with_led_cmd verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ps2kb_pkg.sv
sv/ps2kb_fifo.sv
sv/ps2kb_front.sv
sv/ps2kb_back.sv
sv/scancode_to_ascii_with_led_cmd.sv
sv/ps2kb_checker.sv
dv/tb_top.sv
